>>> design/irblr_pkg.sv
// irblr_pkg: types and constants shared by the ir burst length receiver
// no dependencies; compiled first
`default_nettype none

package irblr_pkg;

	localparam int unsigned LEVEL_W = 4;
	localparam int unsigned VALUE_W = 8;
	localparam int unsigned NUM_OUT = 4;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned ADDR_W  = 4;

	typedef enum logic [0:0] {
		OP_TICK = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef logic [VALUE_W-1:0] value_t;

	// register index taken from paddr[3:2]
	localparam logic [1:0] REG_RELAX_DIVIDER = 2'd0;
	localparam logic [1:0] REG_LAG_LIMIT     = 2'd1;
	localparam logic [1:0] REG_MAX_SPEED     = 2'd2;

	localparam value_t RELAX_DIVIDER_RST = 8'd90;
	localparam value_t LAG_LIMIT_RST     = 8'd4;
	localparam value_t MAX_SPEED_RST     = 8'd2;
	localparam value_t QUIET_TIME_RST    = 8'd5;

endpackage

`default_nettype wire

>>> design/irblr_if.sv
// irblr_item_if and irblr_result_if: valid/ready channels of the receiver
// depends on irblr_pkg
`default_nettype none

interface irblr_item_if;
	logic                                valid;
	logic                                ready;
	irblr_pkg::op_t                      op;
	logic [irblr_pkg::LEVEL_W-1:0]       levels;

	modport source (output valid, output op, output levels, input ready);
	modport sink   (input valid, input op, input levels, output ready);
endinterface

interface irblr_result_if;
	logic                                valid;
	logic                                ready;
	irblr_pkg::value_t                   value_ch0;
	irblr_pkg::value_t                   value_ch1;
	irblr_pkg::value_t                   value_ch2;
	irblr_pkg::value_t                   value_ch3;

	modport source (output valid, output value_ch0, output value_ch1, output value_ch2,
		output value_ch3, input ready);
	modport sink   (input valid, input value_ch0, input value_ch1, input value_ch2,
		input value_ch3, output ready);
endinterface

`default_nettype wire

>>> design/ir_burst_length_receiver.sv
// ir_burst_length_receiver: top level, burst measurement, history filter, apb registers
// depends on irblr_pkg, irblr_item_if and irblr_result_if
`default_nettype none

// Measures infrared burst lengths on CHANNELS receivers and reports a filtered length
// for the first four. Every accepted transaction goes into an input register and is
// worked off in the following cycle by one pass of logic per channel, so one
// transaction per clock is taken and an evaluate result is valid from the clock edge
// after the one that accepted its transaction. A sample tick gives no result. The input
// only stalls while an evaluate waits in the input register behind a result that has
// not been taken. The history filter keeps a running sum per channel and divides it by
// HISTORY_LEN with one reciprocal multiply. The user must write the registers over the
// apb port only while idle; the block itself does not enforce this.
module ir_burst_length_receiver #(
	parameter int unsigned CHANNELS    = 4,
	parameter int unsigned HISTORY_LEN = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	irblr_item_if.sink                           items,
	irblr_result_if.source                       results,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [irblr_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [irblr_pkg::DATA_W-1:0]    pwdata,
	output logic      [irblr_pkg::DATA_W-1:0]    prdata,
	output logic                                 pready
);

	localparam int unsigned HIST_LOG = $clog2(HISTORY_LEN);
	localparam int unsigned SUM_W    = irblr_pkg::VALUE_W + HIST_LOG;
	localparam int unsigned DIV_SH   = SUM_W + HIST_LOG;
	localparam int unsigned RECIP_W  = SUM_W + 1;
	localparam int unsigned PROD_W   = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] DIV_MUL =
		RECIP_W'(((2 ** DIV_SH) + HISTORY_LEN - 1) / HISTORY_LEN);

	// configuration registers
	irblr_pkg::value_t relax_divider_q, lag_limit_q, max_speed_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_divider_q <= irblr_pkg::RELAX_DIVIDER_RST;
			lag_limit_q     <= irblr_pkg::LAG_LIMIT_RST;
			max_speed_q     <= irblr_pkg::MAX_SPEED_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				irblr_pkg::REG_RELAX_DIVIDER: relax_divider_q <= pwdata[7:0];
				irblr_pkg::REG_LAG_LIMIT:     lag_limit_q     <= pwdata[7:0];
				irblr_pkg::REG_MAX_SPEED:     max_speed_q     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			irblr_pkg::REG_RELAX_DIVIDER: prdata = {24'd0, relax_divider_q};
			irblr_pkg::REG_LAG_LIMIT:     prdata = {24'd0, lag_limit_q};
			irblr_pkg::REG_MAX_SPEED:     prdata = {24'd0, max_speed_q};
			default:                      prdata = '0;
		endcase
	end

	// input register
	logic                          s1_valid_q;
	irblr_pkg::op_t                op_s1;
	logic [irblr_pkg::LEVEL_W-1:0] levels_s1;
	logic                          out_valid_q;
	logic                          adv;
	logic                          eval_adv;

	assign adv      = s1_valid_q && (op_s1 == irblr_pkg::OP_TICK || !out_valid_q ||
		results.ready);
	assign eval_adv = adv && op_s1 == irblr_pkg::OP_EVAL;
	assign items.ready = !s1_valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (items.ready) begin
			s1_valid_q <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			op_s1     <= items.op;
			levels_s1 <= items.levels;
		end
	end

	// channel state
	logic                    counting_q   [CHANNELS];
	logic                    last_level_q [CHANNELS];
	irblr_pkg::value_t       burst_count_q[CHANNELS];
	irblr_pkg::value_t       burst_res_q  [CHANNELS];
	irblr_pkg::value_t       quiet_q      [CHANNELS];
	irblr_pkg::value_t       quiet_seen_q [CHANNELS];
	irblr_pkg::value_t       hist_q       [CHANNELS][HISTORY_LEN];
	logic [SUM_W-1:0]        sum_q        [CHANNELS];
	irblr_pkg::value_t       prescale_q;

	logic                    counting_d   [CHANNELS];
	logic                    last_level_d [CHANNELS];
	irblr_pkg::value_t       burst_count_d[CHANNELS];
	irblr_pkg::value_t       burst_res_d  [CHANNELS];
	irblr_pkg::value_t       quiet_d      [CHANNELS];
	irblr_pkg::value_t       quiet_seen_d [CHANNELS];
	irblr_pkg::value_t       hist_d       [CHANNELS][HISTORY_LEN];
	logic [SUM_W-1:0]        sum_d        [CHANNELS];
	irblr_pkg::value_t       prescale_d;
	irblr_pkg::value_t       ch_val       [CHANNELS];

	logic [CHANNELS+irblr_pkg::LEVEL_W-1:0] lv_pad;

	// channels past the level field read idle
	assign lv_pad = {{CHANNELS{1'b1}}, levels_s1};

	always_comb begin
		irblr_pkg::value_t pre_inc;
		logic              relax;
		logic              lv;
		irblr_pkg::value_t qt;
		irblr_pkg::value_t br;
		irblr_pkg::value_t bc;
		irblr_pkg::value_t oldest;
		logic              push;
		logic [SUM_W-1:0]  sm;
		logic [8:0]        diff;
		logic [7:0]        speed;
		logic [PROD_W-1:0] prod;

		pre_inc    = prescale_q + 8'd1;
		relax      = pre_inc > relax_divider_q;
		prescale_d = prescale_q;
		if (adv && op_s1 == irblr_pkg::OP_TICK) begin
			prescale_d = relax ? 8'd0 : pre_inc;
		end

		for (int c = 0; c < CHANNELS; c++) begin
			counting_d[c]    = counting_q[c];
			last_level_d[c]  = last_level_q[c];
			burst_count_d[c] = burst_count_q[c];
			burst_res_d[c]   = burst_res_q[c];
			quiet_d[c]       = quiet_q[c];
			quiet_seen_d[c]  = quiet_seen_q[c];
			sum_d[c]         = sum_q[c];
			for (int k = 0; k < HISTORY_LEN; k++) begin
				hist_d[c][k] = hist_q[c][k];
			end

			// evaluate path
			qt = quiet_q[c];
			br = burst_res_q[c];
			bc = burst_count_q[c];
			if (qt > lag_limit_q) begin
				qt = '0;
				br = '0;
				bc = '0;
			end
			push   = qt != quiet_seen_q[c];
			sm     = push ? sum_q[c] - SUM_W'(hist_q[c][0]) + SUM_W'(br) : sum_q[c];
			oldest = push ? hist_q[c][1] : hist_q[c][0];
			diff   = push ? {1'b0, oldest} - {1'b0, br} :
				{1'b0, oldest} - {1'b0, hist_q[c][HISTORY_LEN-1]};
			speed  = diff[8] ? 8'(-diff) : diff[7:0];
			prod   = PROD_W'(sm) * PROD_W'(DIV_MUL);
			ch_val[c] = (speed > max_speed_q) ? 8'd0 : prod[DIV_SH +: 8];

			// tick path
			lv = lv_pad[c];

			if (adv) begin
				if (op_s1 == irblr_pkg::OP_TICK) begin
					if (relax) begin
						quiet_d[c] = quiet_q[c] + 8'd1;
					end
					if (counting_q[c] && !lv) begin
						burst_count_d[c] = burst_count_q[c] + 8'd1;
					end
					if (lv != last_level_q[c]) begin
						last_level_d[c] = lv;
						quiet_d[c]      = '0;
						if (lv && counting_q[c]) begin
							counting_d[c]  = 1'b0;
							burst_res_d[c] = burst_count_q[c];
						end else if (!lv && !counting_q[c]) begin
							counting_d[c]    = 1'b1;
							burst_count_d[c] = '0;
						end
					end
				end else begin
					quiet_d[c]       = qt;
					burst_res_d[c]   = br;
					burst_count_d[c] = bc;
					if (push) begin
						for (int k = 0; k < HISTORY_LEN - 1; k++) begin
							hist_d[c][k] = hist_q[c][k+1];
						end
						hist_d[c][HISTORY_LEN-1] = br;
						sum_d[c]        = sm;
						quiet_seen_d[c] = qt;
					end
					if (speed > max_speed_q) begin
						burst_res_d[c]   = '0;
						quiet_d[c]       = '0;
						burst_count_d[c] = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				counting_q[c]    <= 1'b0;
				last_level_q[c]  <= 1'b1;
				burst_count_q[c] <= '0;
				burst_res_q[c]   <= '0;
				quiet_q[c]       <= irblr_pkg::QUIET_TIME_RST;
				quiet_seen_q[c]  <= '0;
				sum_q[c]         <= '0;
				for (int k = 0; k < HISTORY_LEN; k++) begin
					hist_q[c][k] <= '0;
				end
			end
		end else begin
			prescale_q <= prescale_d;
			for (int c = 0; c < CHANNELS; c++) begin
				counting_q[c]    <= counting_d[c];
				last_level_q[c]  <= last_level_d[c];
				burst_count_q[c] <= burst_count_d[c];
				burst_res_q[c]   <= burst_res_d[c];
				quiet_q[c]       <= quiet_d[c];
				quiet_seen_q[c]  <= quiet_seen_d[c];
				sum_q[c]         <= sum_d[c];
				for (int k = 0; k < HISTORY_LEN; k++) begin
					hist_q[c][k] <= hist_d[c][k];
				end
			end
		end
	end

	// result register
	irblr_pkg::value_t val_q[irblr_pkg::NUM_OUT];
	irblr_pkg::value_t val_d[irblr_pkg::NUM_OUT];

	for (genvar o = 0; o < irblr_pkg::NUM_OUT; o++) begin : g_out
		if (o < CHANNELS) begin : g_ch
			assign val_d[o] = ch_val[o];
		end else begin : g_none
			assign val_d[o] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eval_adv) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_adv) begin
			for (int o = 0; o < irblr_pkg::NUM_OUT; o++) begin
				val_q[o] <= val_d[o];
			end
		end
	end

	assign results.valid     = out_valid_q;
	assign results.value_ch0 = val_q[0];
	assign results.value_ch1 = val_q[1];
	assign results.value_ch2 = val_q[2];
	assign results.value_ch3 = val_q[3];

	// a result only ever comes from an evaluate transaction in the input register
	a_result_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid_q && op_s1 == irblr_pkg::OP_EVAL))
		else $error("result raised without an evaluate transaction");

	// input only stalls behind an unclaimed result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!items.ready |-> s1_valid_q && out_valid_q && !results.ready)
		else $error("input stalled without a pending result");

	// tick transactions leave the result register alone
	a_tick_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 == irblr_pkg::OP_TICK && results.ready |=> !out_valid_q)
		else $error("tick transaction produced a result");

endmodule

`default_nettype wire

>>> verif/irblr_length_check.sv
// irblr_length_check: watches the receiver's channels and register port, predicts every
// evaluate reading and compares it field by field with what the block returns
// depends on irblr_pkg, irblr_item_if and irblr_result_if
module irblr_length_check import irblr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	irblr_item_if                  items,
	irblr_result_if                results,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              pready,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output int unsigned            readings_owed,
	output int unsigned            fail_count
);

	typedef logic [NUM_OUT-1:0][VALUE_W-1:0] reading_t;

	value_t     relax_div;
	value_t     lag_lim;
	value_t     speed_lim;
	value_t     prescale;
	logic [3:0] counting;
	logic [3:0] last_level;
	value_t     burst_count [4];
	value_t     burst_len [4];
	value_t     quiet [4];
	value_t     quiet_seen [4];
	value_t     hist [4][4];
	logic [1:0] hist_ptr [4];
	reading_t   readings_due [$];

	task automatic sample_levels(input logic [LEVEL_W-1:0] lv);
		int c;
		prescale = prescale + 8'd1;
		if (prescale > relax_div) begin
			prescale = '0;
			for (c = 0; c < 4; c++)
				quiet[c] = quiet[c] + 8'd1;
		end
		for (c = 0; c < 4; c++) begin
			if (counting[c] && !lv[c])
				burst_count[c] = burst_count[c] + 8'd1;
			if (lv[c] != last_level[c]) begin
				last_level[c] = lv[c];
				quiet[c] = '0;
				if (lv[c]) begin
					if (counting[c]) begin
						counting[c] = 1'b0;
						burst_len[c] = burst_count[c];
					end
				end else if (!counting[c]) begin
					counting[c] = 1'b1;
					burst_count[c] = '0;
				end
			end
		end
	endtask

	function automatic value_t filter_channel(input int c);
		logic [9:0] sum;
		logic [1:0] prev_slot;
		value_t     oldest;
		value_t     newest;
		value_t     spread;
		value_t     avg;
		if (quiet[c] > lag_lim) begin
			quiet[c] = '0;
			burst_len[c] = '0;
			burst_count[c] = '0;
		end
		if (quiet[c] != quiet_seen[c]) begin
			hist[c][hist_ptr[c]] = burst_len[c];
			hist_ptr[c] = hist_ptr[c] + 2'd1;
			quiet_seen[c] = quiet[c];
		end
		sum = 10'(hist[c][0]) + 10'(hist[c][1]) + 10'(hist[c][2]) + 10'(hist[c][3]);
		avg = sum[9:2];
		prev_slot = hist_ptr[c] - 2'd1;
		oldest = hist[c][hist_ptr[c]];
		newest = hist[c][prev_slot];
		spread = (oldest >= newest) ? oldest - newest : newest - oldest;
		// too fast a change across the history: reject and start over
		if (spread > speed_lim) begin
			burst_len[c] = '0;
			quiet[c] = '0;
			burst_count[c] = '0;
			avg = '0;
		end
		return avg;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int       c;
		reading_t want;
		reading_t got;
		if (!arst_n) begin
			relax_div = RELAX_DIVIDER_RST;
			lag_lim = LAG_LIMIT_RST;
			speed_lim = MAX_SPEED_RST;
			prescale = '0;
			counting = '0;
			last_level = '1;
			for (c = 0; c < 4; c++) begin
				burst_count[c] = '0;
				burst_len[c] = '0;
				quiet[c] = QUIET_TIME_RST;
				quiet_seen[c] = '0;
				hist_ptr[c] = '0;
				hist[c] = '{default: '0};
			end
			readings_due.delete();
			readings_owed = 0;
			fail_count = 0;
		end else begin
			if (results.valid === 1'b1 && results.ready === 1'b1) begin
				got = {results.value_ch3, results.value_ch2, results.value_ch1,
					results.value_ch0};
				if (readings_due.size() == 0) begin
					$error("result transaction with no evaluate outstanding: %h", got);
					fail_count++;
				end else begin
					want = readings_due.pop_front();
					for (c = 0; c < NUM_OUT; c++) begin
						if (got[c] !== want[c]) begin
							$error("value_ch%0d: expected %0d, actual %0d", c, want[c], got[c]);
							fail_count++;
						end
					end
				end
			end
			if (items.valid === 1'b1 && items.ready === 1'b1) begin
				if (items.op == OP_TICK)
					sample_levels(items.levels);
				else begin
					for (c = 0; c < NUM_OUT; c++)
						want[c] = filter_channel(c);
					readings_due.push_back(want);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_RELAX_DIVIDER: relax_div = pwdata[VALUE_W-1:0];
					REG_LAG_LIMIT:     lag_lim = pwdata[VALUE_W-1:0];
					REG_MAX_SPEED:     speed_lim = pwdata[VALUE_W-1:0];
					default: ;
				endcase
			end
			readings_owed = readings_due.size();
		end
	end

endmodule

>>> verif/tb_top.sv
// tb_top: drives sample ticks, evaluates and register writes into the ir burst length
// receiver and gives the verdict; prediction and comparison sit in irblr_length_check
// depends on irblr_pkg, irblr_item_if, irblr_result_if and ir_burst_length_receiver
module tb_top;
	import irblr_pkg::*;

	localparam logic [1:0] REG_SPARE    = 2'd3;
	localparam int         DRAIN_CYCLES = 6;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int unsigned       readings_owed;
	int unsigned       fail_count;
	int                send_gap_max;
	int                take_stall_max;
	int                n_ticks;
	int                n_evals;
	int                n_settings;

	irblr_item_if   items ();
	irblr_result_if results ();

	ir_burst_length_receiver dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	irblr_length_check length_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.items         (items),
		.results       (results),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.readings_owed (readings_owed),
		.fail_count    (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// result side: random stall before each transaction
	initial begin
		int stall;
		results.ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, take_stall_max);
			if (stall > 0) begin
				results.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (results.valid !== 1'b1);
			@(negedge clk);
		end
	end

	task automatic send_item(input op_t kind, input logic [LEVEL_W-1:0] lv);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		items.valid <= 1'b1;
		items.op <= kind;
		items.levels <= lv;
		do @(posedge clk); while (items.ready !== 1'b1);
		@(negedge clk);
		if (kind == OP_TICK)
			n_ticks++;
		else
			n_evals++;
	endtask

	task automatic settle();
		items.valid <= 1'b0;
		while (readings_owed != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input value_t val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom() & 32'hFFFF_FF00) | DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input value_t div, input value_t lag, input value_t spd);
		settle();
		reg_write(REG_RELAX_DIVIDER, div);
		reg_write(REG_LAG_LIMIT, lag);
		reg_write(REG_MAX_SPEED, spd);
		n_settings++;
		send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
		take_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
	endtask

	// per-channel low/high pattern with a little jitter, some evaluates and some noise
	task automatic run_train(input int n_items);
		int         blen [4];
		int         bgap [4];
		int         left [4];
		logic [3:0] lv;
		int         k;
		int         c;
		int         n;
		lv = 4'hF;
		for (c = 0; c < 4; c++) begin
			blen[c] = $urandom_range(2, 7);
			bgap[c] = $urandom_range(2, 6);
			left[c] = $urandom_range(0, 4);
		end
		for (k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 99) < 3)
				settle();
			if ($urandom_range(0, 99) < 20)
				send_item(OP_EVAL, LEVEL_W'($urandom()));
			else if ($urandom_range(0, 99) < 10)
				send_item(OP_TICK, LEVEL_W'($urandom()));
			else begin
				for (c = 0; c < 4; c++) begin
					if (left[c] == 0) begin
						lv[c] = ~lv[c];
						n = lv[c] ? bgap[c] : blen[c];
						if ($urandom_range(0, 7) == 0)
							n = n + int'($urandom_range(0, 2)) - 1;
						left[c] = n;
					end
					left[c]--;
				end
				send_item(OP_TICK, lv);
			end
		end
	endtask

	initial begin
		int     k;
		int     n_low;
		value_t div;
		value_t lag;
		value_t spd;
		arst_n = 1'b0;
		items.valid = 1'b0;
		items.op = OP_TICK;
		items.levels = '1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_gap_max = 8;
		take_stall_max = 8;
		n_ticks = 0;
		n_evals = 0;
		n_settings = 1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: stale clear on the first evaluate, one short burst
		send_item(OP_EVAL, 4'h0);
		send_item(OP_TICK, 4'hF);
		send_item(OP_TICK, 4'h0);
		send_item(OP_TICK, 4'h0);
		send_item(OP_TICK, 4'h0);
		send_item(OP_TICK, 4'hF);
		send_item(OP_EVAL, 4'hF);

		// quiet time advancing on every tick, nothing stale, no speed limit
		configure(8'd0, 8'd254, 8'd255);
		send_item(OP_TICK, 4'h0);
		send_item(OP_TICK, 4'h0);
		send_item(OP_TICK, 4'h0);
		send_item(OP_TICK, 4'hF);
		send_item(OP_TICK, 4'hF);
		send_item(OP_EVAL, 4'h0);
		send_item(OP_TICK, 4'h3);
		send_item(OP_TICK, 4'hC);
		send_item(OP_TICK, 4'hF);
		send_item(OP_TICK, 4'hF);
		send_item(OP_EVAL, 4'hF);

		// tightest limits: stale channels and speed rejects
		configure(8'd0, 8'd0, 8'd0);
		send_item(OP_TICK, 4'h0);
		send_item(OP_TICK, 4'hF);
		send_item(OP_TICK, 4'hF);
		send_item(OP_EVAL, 4'h5);
		send_item(OP_EVAL, 4'hA);

		for (k = 0; k < 7; k++) begin
			div = ($urandom_range(0, 3) == 0) ? value_t'($urandom_range(0, 255))
				: value_t'($urandom_range(0, 6));
			lag = ($urandom_range(0, 3) == 0) ? value_t'($urandom_range(0, 254))
				: value_t'($urandom_range(0, 12));
			spd = ($urandom_range(0, 3) == 0) ? value_t'($urandom_range(0, 255))
				: value_t'($urandom_range(0, 6));
			configure(div, lag, spd);
			if (k == 2)
				reg_write(REG_SPARE, value_t'($urandom()));
			run_train(20);
		end

		// divider at its maximum freezes quiet time; one burst long enough to wrap
		configure(8'd255, 8'd254, 8'd255);
		send_item(OP_TICK, 4'hF);
		n_low = $urandom_range(257, 270);
		for (k = 0; k < n_low; k++)
			send_item(OP_TICK, {3'($urandom()), 1'b0});
		send_item(OP_TICK, 4'hF);
		send_item(OP_EVAL, 4'h0);
		configure(8'd0, 8'd254, 8'd255);
		send_item(OP_TICK, 4'hF);
		send_item(OP_TICK, 4'hF);
		send_item(OP_EVAL, 4'hF);
		send_item(OP_EVAL, 4'h0);

		configure(8'd1, 8'd3, 8'd1);
		run_train(20);

		settle();
		$display("covered %0d sample ticks and %0d evaluates over %0d register settings",
			n_ticks, n_evals, n_settings);
		$display("bursts with jitter and noise, stale channels, speed rejects, wrapped count");
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
